// ===== rtl/xrr_pkg.sv =====
// Package with constants for the xorshift random-in-range unit.
`timescale 1ns / 1ps

package xrr_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned StepWidth = $clog2(WordWidth);

  localparam logic [WordWidth-1:0] SeedA       = 32'd123456789;
  localparam logic [WordWidth-1:0] SeedB       = 32'd362436069;
  localparam logic [WordWidth-1:0] SeedC       = 32'd521288629;
  localparam logic [WordWidth-1:0] SeedD       = 32'd88675123;
  localparam logic [WordWidth-1:0] CounterInit = 32'd234453234;
  localparam logic [WordWidth-1:0] CounterBias = 32'd3556;

  localparam int unsigned ShiftA = 11;
  localparam int unsigned ShiftD = 19;
  localparam int unsigned ShiftM = 8;

  typedef logic [WordWidth-1:0] word_t;

endpackage

// ===== rtl/xorshift_random_in_range_unit.sv =====
// Top level: xorshift128 random source with per-word bound and serial modulo.
//
//   channel | direction | handshake                  | payload
//   cfg     | in        | cfg_we_i (no wait)         | cfg_wdata_i (seed_increment)
//   in      | in        | in_valid_i / in_ready_o    | range_max_i
//   out     | out       | out_valid_o / out_ready_i  | random_value_o
//
// From acceptance to a valid result a word passes a counter step, a generator
// step, 32 restoring-divider steps and a load step that waits for the output register.
// A full-range bound skips the divider.
// in_ready_o is high only when the sequencer is idle; the output register
// holds one result, so a new word is taken while that result waits.
// Reset restores the seed words, the counter and an increment of CounterBias (zero seed_increment).
`timescale 1ns / 1ps

module xorshift_random_in_range_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [xrr_pkg::WordWidth-1:0]    cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [xrr_pkg::WordWidth-1:0]    range_max_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [xrr_pkg::WordWidth-1:0]    random_value_o
);

  typedef enum logic [2:0] {
    StIdle,
    StCount,
    StMix,
    StDiv,
    StDone
  } state_e;

  state_e state_q, state_d;

  xrr_pkg::word_t wa_q, wa_d, wb_q, wb_d, wc_q, wc_d, wd_q, wd_d;
  xrr_pkg::word_t cnt_q, cnt_d;
  xrr_pkg::word_t inc_q, inc_d;
  xrr_pkg::word_t mod_q, mod_d;
  xrr_pkg::word_t rem_q, rem_d;
  xrr_pkg::word_t dvd_q, dvd_d;
  xrr_pkg::word_t res_q, res_d;
  logic full_q, full_d;
  logic [xrr_pkg::StepWidth-1:0] step_q, step_d;
  logic out_valid_q, out_valid_d;

  xrr_pkg::word_t mix, new_d;
  logic [xrr_pkg::WordWidth:0] rem_sh, rem_sub;
  logic take_in, load_out;

  assign in_ready_o     = (state_q == StIdle);
  assign take_in        = in_valid_i && in_ready_o;
  assign out_valid_o    = out_valid_q;
  assign random_value_o = res_q;
  assign load_out       = (state_q == StDone) && (!out_valid_q || out_ready_i);

  assign mix   = wa_q ^ (wa_q << xrr_pkg::ShiftA);
  assign new_d = ((wd_q ^ (wd_q >> xrr_pkg::ShiftD)) ^ (mix ^ (mix >> xrr_pkg::ShiftM)))
                 - cnt_q;

  assign rem_sh  = {rem_q, dvd_q[xrr_pkg::WordWidth-1]};
  assign rem_sub = rem_sh - {1'b0, mod_q};

  always_comb begin
    state_d     = state_q;
    wa_d        = wa_q;
    wb_d        = wb_q;
    wc_d        = wc_q;
    wd_d        = wd_q;
    cnt_d       = cnt_q;
    inc_d       = inc_q;
    mod_d       = mod_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    res_d       = res_q;
    full_d      = full_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;

    if (cfg_we_i) begin
      inc_d = cfg_wdata_i + xrr_pkg::CounterBias;
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (take_in) begin
          mod_d   = range_max_i + 1'b1;
          full_d  = &range_max_i;
          state_d = StCount;
        end
      end
      StCount: begin
        cnt_d   = cnt_q + inc_q;
        state_d = StMix;
      end
      StMix: begin
        wa_d   = wb_q;
        wb_d   = wc_q;
        wc_d   = wd_q;
        wd_d   = new_d;
        dvd_d  = new_d;
        step_d = '0;
        if (full_q) begin
          rem_d   = new_d;
          state_d = StDone;
        end else begin
          rem_d   = '0;
          state_d = StDiv;
        end
      end
      StDiv: begin
        dvd_d = dvd_q << 1;
        if (!rem_sub[xrr_pkg::WordWidth]) begin
          rem_d = rem_sub[xrr_pkg::WordWidth-1:0];
        end else begin
          rem_d = rem_sh[xrr_pkg::WordWidth-1:0];
        end
        step_d = step_q + 1'b1;
        if (&step_q) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (load_out) begin
          res_d       = rem_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      wa_q        <= xrr_pkg::SeedA;
      wb_q        <= xrr_pkg::SeedB;
      wc_q        <= xrr_pkg::SeedC;
      wd_q        <= xrr_pkg::SeedD;
      cnt_q       <= xrr_pkg::CounterInit;
      inc_q       <= xrr_pkg::CounterBias;
      full_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wa_q        <= wa_d;
      wb_q        <= wb_d;
      wc_q        <= wc_d;
      wd_q        <= wd_d;
      cnt_q       <= cnt_d;
      inc_q       <= inc_d;
      full_q      <= full_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mod_q <= mod_d;
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    res_q <= res_d;
  end

endmodule

// ===== sim/xorshift_random_in_range_unit_tb.sv =====
// Testbench for the xorshift random-in-range unit: random and directed bounds vs. a predictor.
`timescale 1ns / 1ps

module xorshift_random_in_range_unit_tb;

  localparam int unsigned    RandomPhases   = 5;
  localparam int unsigned    WordsPerPhase  = 350;
  localparam int unsigned    DrainEvery     = 100;
  localparam xrr_pkg::word_t AllOnes        = {xrr_pkg::WordWidth{1'b1}};
  localparam xrr_pkg::word_t BiasCancel     = xrr_pkg::word_t'(0) - xrr_pkg::CounterBias;

  logic           clk_i;
  logic           rst_ni;
  logic           cfg_we_i;
  xrr_pkg::word_t cfg_wdata_i;
  logic           in_valid_i;
  logic           in_ready_o;
  xrr_pkg::word_t range_max_i;
  logic           out_valid_o;
  logic           out_ready_i;
  xrr_pkg::word_t random_value_o;

  xrr_pkg::word_t gen_a, gen_b, gen_c, gen_d, add_counter, seed_increment;
  xrr_pkg::word_t expected_randoms[$];
  int unsigned mismatch_count;
  bit sender_idles, receiver_idles;

  xorshift_random_in_range_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .range_max_i    (range_max_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .random_value_o (random_value_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void reset_generator();
    gen_a          = xrr_pkg::SeedA;
    gen_b          = xrr_pkg::SeedB;
    gen_c          = xrr_pkg::SeedC;
    gen_d          = xrr_pkg::SeedD;
    add_counter    = xrr_pkg::CounterInit;
    seed_increment = '0;
  endfunction

  function automatic xrr_pkg::word_t predict_random(input xrr_pkg::word_t bound);
    xrr_pkg::word_t mix, fresh, span;
    mix         = gen_a ^ (gen_a << xrr_pkg::ShiftA);
    add_counter = add_counter + seed_increment + xrr_pkg::CounterBias;
    fresh       = ((gen_d ^ (gen_d >> xrr_pkg::ShiftD)) ^ (mix ^ (mix >> xrr_pkg::ShiftM)))
                  - add_counter;
    gen_a       = gen_b;
    gen_b       = gen_c;
    gen_c       = gen_d;
    gen_d       = fresh;
    span        = bound + 1'b1;
    return (span == '0) ? fresh : fresh % span;
  endfunction

  function automatic xrr_pkg::word_t random_bound();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 255);
      1: return AllOnes >> $urandom_range(0, 31);
      2: return AllOnes - $urandom_range(0, 3);
      3: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_bound(input xrr_pkg::word_t bound);
    int unsigned gap;
    gap = sender_idles ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    range_max_i <= bound;
    do @(posedge clk_i); while (!in_ready_o);
    expected_randoms.push_back(predict_random(bound));
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (expected_randoms.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_increment(input xrr_pkg::word_t value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    seed_increment = value;
  endtask

  task automatic test_reset_state();
    xrr_pkg::word_t bounds[$];
    bounds = {32'd0, AllOnes, 32'd1, 32'd2, 32'd3, 32'h7FFF_FFFF, 32'h8000_0000,
              32'hFFFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_0000};
    foreach (bounds[i]) send_bound(bounds[i]);
    wait_for_results();
  endtask

  // back to back on both sides; increment extremes, one that cancels the bias
  task automatic test_increment_extremes();
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    write_increment(AllOnes);
    send_bound(AllOnes);
    send_bound(32'd0);
    send_bound(32'd9);
    send_bound(32'h8000_0001);
    wait_for_results();
    write_increment(BiasCancel);
    send_bound(AllOnes);
    send_bound(AllOnes);
    send_bound(32'd12345);
    wait_for_results();
    write_increment('0);
    send_bound(AllOnes);
    wait_for_results();
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
  endtask

  task automatic test_random_bounds();
    xrr_pkg::word_t increments[RandomPhases];
    increments = '{$urandom, '0, AllOnes, $urandom, BiasCancel};
    for (int unsigned p = 0; p < RandomPhases; p++) begin
      sender_idles   = (p != 2);
      receiver_idles = (p != 2) && (p != 3);
      write_increment(increments[p]);
      for (int unsigned n = 0; n < WordsPerPhase; n++) begin
        send_bound(random_bound());
        if (n % DrainEvery == DrainEvery - 1) wait_for_results();
      end
      wait_for_results();
    end
  endtask

  initial begin : result_check
    int unsigned stall;
    xrr_pkg::word_t want;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = receiver_idles ? $urandom_range(0, 15) : 0;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        do @(posedge clk_i); while (!out_valid_o);
        repeat (stall - 1) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (expected_randoms.size() == 0) begin
        $error("random_value: no word expected, actual %0d", random_value_o);
        mismatch_count++;
      end else begin
        want = expected_randoms.pop_front();
        if (random_value_o !== want) begin
          $error("random_value: expected %0d, actual %0d", want, random_value_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    range_max_i    = '0;
    mismatch_count = 0;
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    reset_generator();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_increment_extremes();
    test_random_bounds();
    wait_for_results();
    repeat (50) @(posedge clk_i);
    if (expected_randoms.size() != 0) begin
      $error("random_value: %0d words never arrived", expected_randoms.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("** xorshift_random_in_range_unit: PASSED **");
    end else begin
      $display("** xorshift_random_in_range_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("** xorshift_random_in_range_unit: FAILED **");
    $finish;
  end

endmodule
